// ===== rtl/core/lgl_pkg.sv =====
// Package for the luma gamma table pixel block.
// Holds the item class codes, the queue entry type, matrix constants and the clamp helper.
// No dependencies.
`default_nettype none

package lgl_pkg;

    // Input item action codes.
    localparam logic ACTION_LOAD  = 1'b0;
    localparam logic ACTION_PIXEL = 1'b1;

    // Register byte addresses.
    localparam int          PADDR_W       = 3;
    localparam logic [2:0]  ADDR_BYPASS   = 3'd0;
    localparam logic [2:0]  ADDR_RGB_MODE = 3'd4;

    localparam int LUT_ENTRIES = 256;
    localparam int LUT_ADDR_W  = $clog2(LUT_ENTRIES);

    // Forward BT.601 matrix (RGB to YCbCr), shift right by 8 after the sum.
    localparam int YCC_Y_A  = 66;
    localparam int YCC_Y_B  = 129;
    localparam int YCC_Y_C  = 25;
    localparam int YCC_Y_K  = 4096;
    localparam int YCC_U_A  = -38;
    localparam int YCC_U_B  = -74;
    localparam int YCC_U_C  = 112;
    localparam int YCC_U_K  = 32768;
    localparam int YCC_V_A  = 112;
    localparam int YCC_V_B  = -94;
    localparam int YCC_V_C  = -18;
    localparam int YCC_V_K  = 32768;

    // Inverse matrix (YCbCr to RGB); terms with a zero coefficient are left out.
    localparam int RGB_Y    = 298;
    localparam int RGB_R_V  = 409;
    localparam int RGB_R_K  = -57068;
    localparam int RGB_G_U  = -100;
    localparam int RGB_G_V  = -208;
    localparam int RGB_G_K  = 34707;
    localparam int RGB_B_U  = 516;
    localparam int RGB_B_K  = -70870;

    typedef enum logic [1:0] {
        OP_LOAD,
        OP_PASS,
        OP_LUMA,
        OP_RGB
    } op_t;

    typedef struct packed {
        logic bypass;
        logic rgb_mode;
    } cfg_t;

    // One classified item as it travels from the front part to the back part.
    // lut_addr is the write index for a load and the read index for a mapped pixel.
    typedef struct packed {
        op_t                    op;
        logic [LUT_ADDR_W-1:0]  lut_addr;
        logic [7:0]             lut_value;
        logic [7:0]             comp_a;
        logic [7:0]             comp_b;
        logic [7:0]             comp_c;
        logic signed [9:0]      cb;
        logic signed [9:0]      cr;
    } entry_t;

    function automatic logic [7:0] clamp8(input logic signed [11:0] x);
        logic [7:0] r;
        if (x < 12'sd0) begin
            r = 8'd0;
        end else if (x > 12'sd255) begin
            r = 8'd255;
        end else begin
            r = x[7:0];
        end
        return r;
    endfunction

endpackage

`default_nettype wire

// ===== rtl/core/lgl_front.sv =====
// Front part: classifies an incoming item and runs the forward color matrix.
// Depends on lgl_pkg.
`default_nettype none

module lgl_front (
    input  wire logic [7:0]     s_lut_index,
    input  wire logic           s_action,
    input  wire logic [7:0]     s_lut_value,
    input  wire logic [7:0]     s_comp_a,
    input  wire logic [7:0]     s_comp_b,
    input  wire logic [7:0]     s_comp_c,
    input  wire lgl_pkg::cfg_t  cfg,
    output lgl_pkg::entry_t     entry
);
    import lgl_pkg::*;

    logic signed [17:0] a_s, b_s, c_s;
    logic signed [17:0] y_sum, u_sum, v_sum;
    logic signed [9:0]  y_sh;
    logic [7:0]         y_clamped;

    assign a_s = signed'(18'(s_comp_a));
    assign b_s = signed'(18'(s_comp_b));
    assign c_s = signed'(18'(s_comp_c));

    assign y_sum = 18'(a_s * YCC_Y_A + b_s * YCC_Y_B + c_s * YCC_Y_C + YCC_Y_K);
    assign u_sum = 18'(a_s * YCC_U_A + b_s * YCC_U_B + c_s * YCC_U_C + YCC_U_K);
    assign v_sum = 18'(a_s * YCC_V_A + b_s * YCC_V_B + c_s * YCC_V_C + YCC_V_K);

    assign y_sh      = 10'(y_sum >>> 8);
    assign y_clamped = clamp8(12'(y_sh));

    always_comb begin
        entry.lut_value = s_lut_value;
        entry.comp_a    = s_comp_a;
        entry.comp_b    = s_comp_b;
        entry.comp_c    = s_comp_c;
        entry.cb        = 10'(u_sum >>> 8);
        entry.cr        = 10'(v_sum >>> 8);
        if (s_action == ACTION_LOAD) begin
            entry.op       = OP_LOAD;
            entry.lut_addr = s_lut_index;
        end else if (cfg.bypass) begin
            entry.op       = OP_PASS;
            entry.lut_addr = s_comp_a;
        end else if (!cfg.rgb_mode) begin
            entry.op       = OP_LUMA;
            entry.lut_addr = s_comp_a;
        end else begin
            entry.op       = OP_RGB;
            entry.lut_addr = y_clamped;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/core/lgl_queue.sv =====
// Short FIFO of classified items between the front and back parts.
// Depends on lgl_pkg for the entry type.
`default_nettype none

module lgl_queue #(
    parameter int DEPTH = 4
) (
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire logic             push_valid,
    output logic                  push_ready,
    input  wire lgl_pkg::entry_t  push_data,
    output logic                  pop_valid,
    input  wire logic             pop_ready,
    output lgl_pkg::entry_t       pop_data
);
    import lgl_pkg::*;

    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    entry_t             slots_reg [DEPTH];
    logic [PTR_W-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0]   count_reg, count_next;
    logic               do_push, do_pop;

    assign push_ready = (count_reg != CNT_W'(DEPTH));
    assign pop_valid  = (count_reg != '0);
    assign pop_data   = slots_reg[rd_ptr_reg];
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop_valid && pop_ready;

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push) begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop) begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop) begin
            count_next = count_reg + 1'b1;
        end else if (do_pop && !do_push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (do_push) begin
            slots_reg[wr_ptr_reg] <= push_data;
        end
    end

    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CNT_W'(DEPTH))
        else $error("queue count exceeds depth");

    a_push_only_grows: assert property (@(posedge aclk) disable iff (!aresetn)
        (do_push && !do_pop) |=> (count_reg == $past(count_reg) + 1'b1))
        else $error("queue count did not grow on push");

    a_pointers_agree: assert property (@(posedge aclk) disable iff (!aresetn)
        (count_reg == '0) |-> (wr_ptr_reg == rd_ptr_reg))
        else $error("empty queue with pointers apart");

endmodule

`default_nettype wire

// ===== rtl/core/lgl_back.sv =====
// Back part: gamma table memory, table read stage and the inverse color matrix
// with clamping into the output register. Depends on lgl_pkg.
`default_nettype none

module lgl_back (
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire logic             q_valid,
    output logic                  q_ready,
    input  wire lgl_pkg::entry_t  q_entry,
    output logic                  m_valid,
    input  wire logic             m_ready,
    output logic [7:0]            m_out_a,
    output logic [7:0]            m_out_b,
    output logic [7:0]            m_out_c
);
    import lgl_pkg::*;

    logic [7:0]         lut_mem [LUT_ENTRIES];
    logic [7:0]         lut_q_reg;

    logic               s1_valid_reg;
    op_t                s1_op_reg;
    logic [7:0]         s1_a_reg, s1_b_reg, s1_c_reg;
    logic signed [9:0]  s1_cb_reg, s1_cr_reg;

    logic               out_valid_reg;
    logic [7:0]         out_a_reg, out_b_reg, out_c_reg;
    logic [7:0]         out_a_next, out_b_next, out_c_next;

    logic               adv1, adv2, do_pop;
    logic signed [19:0] y_s, u_s, v_s;
    logic signed [19:0] r_sum, g_sum, b_sum;

    assign adv2    = !out_valid_reg || m_ready;
    assign adv1    = !s1_valid_reg || adv2;
    assign q_ready = adv1;
    assign do_pop  = q_valid && adv1;

    // Table: loads write it, pixels read it; the read data is registered.
    always_ff @(posedge aclk) begin
        if (do_pop && q_entry.op == OP_LOAD) begin
            lut_mem[q_entry.lut_addr] <= q_entry.lut_value;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv1) begin
            lut_q_reg <= lut_mem[q_entry.lut_addr];
        end
    end

    // Stage 1 holds the pixel while the table is read. Loads end here.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg <= 1'b0;
        end else if (adv1) begin
            s1_valid_reg <= do_pop && (q_entry.op != OP_LOAD);
        end
    end

    always_ff @(posedge aclk) begin
        if (adv1) begin
            s1_op_reg <= q_entry.op;
            s1_a_reg  <= q_entry.comp_a;
            s1_b_reg  <= q_entry.comp_b;
            s1_c_reg  <= q_entry.comp_c;
            s1_cb_reg <= q_entry.cb;
            s1_cr_reg <= q_entry.cr;
        end
    end

    assign y_s = signed'(20'(lut_q_reg));
    assign u_s = 20'(s1_cb_reg);
    assign v_s = 20'(s1_cr_reg);

    assign r_sum = 20'(y_s * RGB_Y + v_s * RGB_R_V + RGB_R_K);
    assign g_sum = 20'(y_s * RGB_Y + u_s * RGB_G_U + v_s * RGB_G_V + RGB_G_K);
    assign b_sum = 20'(y_s * RGB_Y + u_s * RGB_B_U + RGB_B_K);

    always_comb begin
        case (s1_op_reg)
            OP_LUMA: begin
                out_a_next = lut_q_reg;
                out_b_next = s1_b_reg;
                out_c_next = s1_c_reg;
            end
            OP_RGB: begin
                out_a_next = clamp8(12'(r_sum >>> 8));
                out_b_next = clamp8(12'(g_sum >>> 8));
                out_c_next = clamp8(12'(b_sum >>> 8));
            end
            default: begin
                out_a_next = s1_a_reg;
                out_b_next = s1_b_reg;
                out_c_next = s1_c_reg;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (adv2) begin
            out_valid_reg <= s1_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv2 && s1_valid_reg) begin
            out_a_reg <= out_a_next;
            out_b_reg <= out_b_next;
            out_c_reg <= out_c_next;
        end
    end

    assign m_valid = out_valid_reg;
    assign m_out_a = out_a_reg;
    assign m_out_b = out_b_reg;
    assign m_out_c = out_c_reg;

    a_load_no_result: assert property (@(posedge aclk) disable iff (!aresetn)
        (do_pop && q_entry.op == OP_LOAD) |=> !s1_valid_reg)
        else $error("load item entered the pixel stage");

    // Pass-through pixels may read entries that were never loaded, so compare with ===.
    a_s1_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        (s1_valid_reg && !adv2) |=> (s1_valid_reg && (lut_q_reg === $past(lut_q_reg))))
        else $error("stalled pixel lost its table data");

    a_no_pop_on_stall: assert property (@(posedge aclk) disable iff (!aresetn)
        (out_valid_reg && !m_ready && s1_valid_reg) |-> !q_ready)
        else $error("queue popped while the pipeline is full");

endmodule

`default_nettype wire

// ===== rtl/core/luma_gamma_lut_pixel.sv =====
// Channel   | Direction | Handshake          | Payload
// s_ (item) | in        | s_valid / s_ready  | s_action, s_lut_index, s_lut_value, s_comp_a..c
// m_ (item) | out       | m_valid / m_ready  | m_out_a, m_out_b, m_out_c
// APB       | in        | psel/penable/pready| paddr, pwrite, pwdata, prdata (bypass, rgb_mode)
//
// One item is taken every cycle while s_ready is high; a pixel accepted at an edge is written into
// the queue, then popped into the table read register and stage 1, then registered in the output
// register, from which it is shown on m_valid. The gamma table memory has one write and one
// registered read port, used by one item a cycle.
// aresetn is synchronous and active low; it empties the queue and pipeline, sets bypass
// and clears rgb_mode. The table keeps no reset value and must be loaded before use.
// A stall on m_ready backs up into the queue; s_ready drops only when the queue is full.
`default_nettype none

module luma_gamma_lut_pixel #(
    parameter int QUEUE_DEPTH = 4
) (
    input  wire logic                       aclk,
    input  wire logic                       aresetn,
    input  wire logic                       s_valid,
    output logic                            s_ready,
    input  wire logic                       s_action,
    input  wire logic [7:0]                 s_lut_index,
    input  wire logic [7:0]                 s_lut_value,
    input  wire logic [7:0]                 s_comp_a,
    input  wire logic [7:0]                 s_comp_b,
    input  wire logic [7:0]                 s_comp_c,
    output logic                            m_valid,
    input  wire logic                       m_ready,
    output logic [7:0]                      m_out_a,
    output logic [7:0]                      m_out_b,
    output logic [7:0]                      m_out_c,
    input  wire logic                       psel,
    input  wire logic                       penable,
    input  wire logic                       pwrite,
    input  wire logic [lgl_pkg::PADDR_W-1:0] paddr,
    input  wire logic [31:0]                pwdata,
    output logic [31:0]                     prdata,
    output logic                            pready
);
    import lgl_pkg::*;

    logic   bypass_reg;
    logic   rgb_mode_reg;
    logic   cfg_write;
    cfg_t   cfg;
    entry_t front_entry;
    entry_t queue_entry;
    logic   queue_valid;
    logic   queue_ready;

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            bypass_reg   <= 1'b1;
            rgb_mode_reg <= 1'b0;
        end else if (cfg_write) begin
            if (paddr == ADDR_BYPASS) begin
                bypass_reg <= pwdata[0];
            end
            if (paddr == ADDR_RGB_MODE) begin
                rgb_mode_reg <= pwdata[0];
            end
        end
    end

    always_comb begin
        unique case (paddr)
            ADDR_BYPASS:   prdata = 32'(bypass_reg);
            ADDR_RGB_MODE: prdata = 32'(rgb_mode_reg);
            default:       prdata = '0;
        endcase
    end

    assign cfg.bypass   = bypass_reg;
    assign cfg.rgb_mode = rgb_mode_reg;

    lgl_front u_front (
        .s_lut_index (s_lut_index),
        .s_action    (s_action),
        .s_lut_value (s_lut_value),
        .s_comp_a    (s_comp_a),
        .s_comp_b    (s_comp_b),
        .s_comp_c    (s_comp_c),
        .cfg         (cfg),
        .entry       (front_entry)
    );

    lgl_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push_valid (s_valid),
        .push_ready (s_ready),
        .push_data  (front_entry),
        .pop_valid  (queue_valid),
        .pop_ready  (queue_ready),
        .pop_data   (queue_entry)
    );

    lgl_back u_back (
        .aclk    (aclk),
        .aresetn (aresetn),
        .q_valid (queue_valid),
        .q_ready (queue_ready),
        .q_entry (queue_entry),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_out_a (m_out_a),
        .m_out_b (m_out_b),
        .m_out_c (m_out_c)
    );

endmodule

`default_nettype wire
